[hdl/round_robin_rank_coordinate_generator_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the rank coordinate generator checker
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_RANK_COORDINATE_GENERATOR_TOP_MACROS_SVH
`define ROUND_ROBIN_RANK_COORDINATE_GENERATOR_TOP_MACROS_SVH

// Consequent checked in the same cycle
`define RRCG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrcg assertion failed");

// Consequent checked in the following cycle
`define RRCG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrcg assertion failed");

`endif

[hdl/rrcg_pkg.sv]
// ----------------------------------------------------------------------------
// rrcg_pkg
// Shared widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrcg_pkg;

    localparam int IDX_W   = 26;   // node index
    localparam int TGT_W   = 28;   // target node, also divider dividend
    localparam int DVS_W   = 11;   // divisor / clamped group count
    localparam int CR_W    = 13;   // chassis * routers
    localparam int N_W     = 17;   // nodes per group
    localparam int RM_W    = 10;   // group slot
    localparam int PROD_W  = 27;   // slot * nodes per group
    localparam int DCNT_W  = 5;    // divider iteration counter
    localparam int WIDX_W  = 3;    // register index
    localparam int WDAT_W  = 11;   // register data

    localparam int MAX_CORES  = 64;
    localparam int MAX_GROUPS = 1024;

    localparam logic [WIDX_W-1:0] REG_GROUP   = 3'd0;
    localparam logic [WIDX_W-1:0] REG_CHASSIS = 3'd1;
    localparam logic [WIDX_W-1:0] REG_ROUTER  = 3'd2;
    localparam logic [WIDX_W-1:0] REG_PCI     = 3'd3;
    localparam logic [WIDX_W-1:0] REG_CORE    = 3'd4;

    // Which division the shared divider is doing
    typedef enum logic [2:0] {
        STG_SPLIT,
        STG_PCI,
        STG_ROUTER,
        STG_CHASSIS,
        STG_GROUP
    } stage_t;

    typedef struct packed {
        logic   load;
        logic   mul_cr;
        logic   mul_n;
        logic   div_start;
        logic   mul_t;
        logic   add_t;
        logic   row_emit;
        stage_t stage;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_row;
    } status_t;

endpackage

[hdl/rrcg_div.sv]
// ----------------------------------------------------------------------------
// rrcg_div
// Restoring divider, one quotient bit per cycle; done pulses after TGT_W steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrcg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rrcg_pkg::TGT_W-1:0]  dividend,
    input  logic [rrcg_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [rrcg_pkg::TGT_W-1:0]  quot,
    output logic [rrcg_pkg::DVS_W-1:0]  rem
);
    import rrcg_pkg::*;

    logic [TGT_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              done_reg;
    logic [DVS_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg, dvd_reg[TGT_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next = ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : DVS_W'(rem_sh);
        dvd_next = {dvd_reg[TGT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == DCNT_W'(1));
            if (start)
                cnt_reg <= DCNT_W'(TGT_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = dvd_reg;
    assign rem  = rem_reg;

endmodule

[hdl/rrcg_dp.sv]
// ----------------------------------------------------------------------------
// rrcg_dp
// Datapath: count registers, multipliers, shared divider and row output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrcg_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rrcg_pkg::cmd_t              cmd,
    output rrcg_pkg::status_t           status,
    input  logic                        wr_en,
    input  logic [rrcg_pkg::WIDX_W-1:0] wr_index,
    input  logic [rrcg_pkg::WDAT_W-1:0] wr_data,
    input  logic [rrcg_pkg::IDX_W-1:0]  node_index,
    output logic                        result_strobe,
    output logic [9:0]                  group_coord,
    output logic [5:0]                  chassis_coord,
    output logic [5:0]                  router_coord,
    output logic [3:0]                  pci_coord,
    output logic [5:0]                  core_coord,
    output logic                        last_row
);
    import rrcg_pkg::*;

    logic [10:0] grp_cfg_reg;
    logic [6:0]  chs_cfg_reg, rtr_cfg_reg, core_cfg_reg;
    logic [4:0]  pci_cfg_reg;

    logic [DVS_W-1:0] g_cl;
    logic [6:0]       c_cl, r_cl, k_cl;
    logic [4:0]       p_cl;

    logic [CR_W-1:0]   cr_reg;
    logic [N_W-1:0]    n_reg;
    logic [TGT_W-1:0]  t_reg;
    logic [IDX_W-1:0]  q_reg;
    logic [RM_W-1:0]   rm_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [3:0]        pci_reg;
    logic [5:0]        rtr_reg, chs_reg;
    logic [9:0]        grp_reg;
    logic [5:0]        core_reg;

    logic              strobe_reg, last_out_reg;
    logic [9:0]        grp_out_reg;
    logic [5:0]        chs_out_reg, rtr_out_reg, core_out_reg;
    logic [3:0]        pci_out_reg;

    logic [DVS_W-1:0]  divisor;
    logic              div_done;
    logic [TGT_W-1:0]  quot;
    logic [DVS_W-1:0]  rem;
    logic              row_last;

    // Zero counts act as 1, oversize counts as the top of their range
    always_comb
    begin
        g_cl = (grp_cfg_reg == '0) ? DVS_W'(1) :
               (grp_cfg_reg > DVS_W'(MAX_GROUPS)) ? DVS_W'(MAX_GROUPS) : grp_cfg_reg;
        c_cl = (chs_cfg_reg == '0) ? 7'd1 : (chs_cfg_reg > 7'd64) ? 7'd64 : chs_cfg_reg;
        r_cl = (rtr_cfg_reg == '0) ? 7'd1 : (rtr_cfg_reg > 7'd64) ? 7'd64 : rtr_cfg_reg;
        p_cl = (pci_cfg_reg == '0) ? 5'd1 : (pci_cfg_reg > 5'd16) ? 5'd16 : pci_cfg_reg;
        k_cl = (core_cfg_reg == '0) ? 7'd1 :
               (core_cfg_reg > 7'(MAX_CORES)) ? 7'(MAX_CORES) : core_cfg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_cfg_reg  <= 11'd1;
            chs_cfg_reg  <= 7'd1;
            rtr_cfg_reg  <= 7'd1;
            pci_cfg_reg  <= 5'd1;
            core_cfg_reg <= 7'd1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_GROUP:   grp_cfg_reg  <= wr_data;
                REG_CHASSIS: chs_cfg_reg  <= wr_data[6:0];
                REG_ROUTER:  rtr_cfg_reg  <= wr_data[6:0];
                REG_PCI:     pci_cfg_reg  <= wr_data[4:0];
                REG_CORE:    core_cfg_reg <= wr_data[6:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cmd.stage)
            STG_PCI:     divisor = DVS_W'(p_cl);
            STG_ROUTER:  divisor = DVS_W'(r_cl);
            STG_CHASSIS: divisor = DVS_W'(c_cl);
            default:     divisor = g_cl;
        endcase
    end

    rrcg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (t_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    assign row_last = ({1'b0, core_reg} + 7'd1) == k_cl;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t_reg    <= TGT_W'(node_index);
            core_reg <= '0;
        end
        if (cmd.mul_cr)
            cr_reg <= CR_W'(c_cl) * CR_W'(r_cl);
        if (cmd.mul_n)
            n_reg <= N_W'(cr_reg) * N_W'(p_cl);
        if (cmd.mul_t)
            prod_reg <= PROD_W'(rm_reg) * PROD_W'(n_reg);
        if (cmd.add_t)
            t_reg <= TGT_W'(prod_reg) + TGT_W'(q_reg);
        if (div_done)
        begin
            unique case (cmd.stage)
                STG_SPLIT:
                begin
                    q_reg  <= quot[IDX_W-1:0];
                    rm_reg <= rem[RM_W-1:0];
                end
                STG_PCI:
                begin
                    pci_reg <= rem[3:0];
                    t_reg   <= quot;
                end
                STG_ROUTER:
                begin
                    rtr_reg <= rem[5:0];
                    t_reg   <= quot;
                end
                STG_CHASSIS:
                begin
                    chs_reg <= rem[5:0];
                    t_reg   <= quot;
                end
                default: grp_reg <= rem[9:0];
            endcase
        end
        if (cmd.row_emit)
        begin
            core_reg     <= core_reg + 6'd1;
            grp_out_reg  <= grp_reg;
            chs_out_reg  <= chs_reg;
            rtr_out_reg  <= rtr_reg;
            pci_out_reg  <= pci_reg;
            core_out_reg <= core_reg;
            last_out_reg <= row_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.row_emit;
    end

    assign status.div_done = div_done;
    assign status.last_row = row_last;

    assign result_strobe = strobe_reg;
    assign group_coord   = grp_out_reg;
    assign chassis_coord = chs_out_reg;
    assign router_coord  = rtr_out_reg;
    assign pci_coord     = pci_out_reg;
    assign core_coord    = core_out_reg;
    assign last_row      = last_out_reg;

endmodule

[hdl/rrcg_ctrl.sv]
// ----------------------------------------------------------------------------
// rrcg_ctrl
// Controller: sequences the multiplies, the five divisions and row output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrcg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output rrcg_pkg::cmd_t      cmd,
    input  rrcg_pkg::status_t   status
);
    import rrcg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_CR,
        S_MUL_N,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MUL_T,
        S_ADD,
        S_EMIT
    } state_t;

    state_t state_reg;
    stage_t stage_reg;
    logic   busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stage_reg <= STG_SPLIT;
            busy_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        state_reg <= S_MUL_CR;
                        stage_reg <= STG_SPLIT;
                        busy_reg  <= 1'b1;
                    end
                S_MUL_CR: state_reg <= S_MUL_N;
                S_MUL_N:  state_reg <= S_DIV_GO;
                S_DIV_GO: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                    if (status.div_done)
                    begin
                        unique case (stage_reg)
                            STG_SPLIT:   state_reg <= S_MUL_T;
                            STG_PCI:
                            begin
                                stage_reg <= STG_ROUTER;
                                state_reg <= S_DIV_GO;
                            end
                            STG_ROUTER:
                            begin
                                stage_reg <= STG_CHASSIS;
                                state_reg <= S_DIV_GO;
                            end
                            STG_CHASSIS:
                            begin
                                stage_reg <= STG_GROUP;
                                state_reg <= S_DIV_GO;
                            end
                            default:     state_reg <= S_EMIT;
                        endcase
                    end
                S_MUL_T:  state_reg <= S_ADD;
                S_ADD:
                begin
                    stage_reg <= STG_PCI;
                    state_reg <= S_DIV_GO;
                end
                S_EMIT:
                    if (status.last_row)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                    end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.stage     = stage_reg;
        cmd.load      = (state_reg == S_IDLE) && start;
        cmd.mul_cr    = (state_reg == S_MUL_CR);
        cmd.mul_n     = (state_reg == S_MUL_N);
        cmd.div_start = (state_reg == S_DIV_GO);
        cmd.mul_t     = (state_reg == S_MUL_T);
        cmd.add_t     = (state_reg == S_ADD);
        cmd.row_emit  = (state_reg == S_EMIT);
    end

    assign busy = busy_reg;

endmodule

[hdl/round_robin_rank_coordinate_generator_top.sv]
// ----------------------------------------------------------------------------
// round_robin_rank_coordinate_generator_top
// Maps a job-node position to per-core rank coordinates, round robin by group.
// ----------------------------------------------------------------------------
// Usage
//   Input: raise start with node_index; the item is taken at a clock edge with
//   start high and busy low. busy stays high until the last row is issued.
//   Output: one row per core (core_count rows, cores ascending). Each row is
//   valid for exactly one cycle while result_strobe is high; the final row
//   carries last_row. The receiver cannot stall, so rows are never held.
//   Config: wr_en / wr_index / wr_data write the five count registers
//   (group, chassis, router, pci, core); other indexes are ignored. Write
//   only while busy is low. Zero counts act as 1, oversize as the range top.
//   Timing: rows come back to back. Each item runs on the shared
//   one-bit-per-cycle divider: five 28-step divisions (split by groups,
//   then by pci, router, chassis and group), plus three multiplies and
//   one add.
//   Reset: rst_n (asynchronous, active low) clears the controller, the strobe
//   and sets every count register to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_rank_coordinate_generator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rrcg_pkg::IDX_W-1:0]  node_index,
    input  logic                        wr_en,
    input  logic [rrcg_pkg::WIDX_W-1:0] wr_index,
    input  logic [rrcg_pkg::WDAT_W-1:0] wr_data,
    output logic                        result_strobe,
    output logic [9:0]                  group_coord,
    output logic [5:0]                  chassis_coord,
    output logic [5:0]                  router_coord,
    output logic [3:0]                  pci_coord,
    output logic [5:0]                  core_coord,
    output logic                        last_row
);
    import rrcg_pkg::*;

    // Command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    rrcg_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    // Datapath holds the count registers, so writes go straight in
    rrcg_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .node_index    (node_index),
        .result_strobe (result_strobe),
        .group_coord   (group_coord),
        .chassis_coord (chassis_coord),
        .router_coord  (router_coord),
        .pci_coord     (pci_coord),
        .core_coord    (core_coord),
        .last_row      (last_row)
    );

endmodule

[hdl/rrcg_checker.sv]
// ----------------------------------------------------------------------------
// rrcg_checker
// Port-level checks on row sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "round_robin_rank_coordinate_generator_top_macros.svh"

module rrcg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_strobe,
    input logic [5:0] core_coord,
    input logic       last_row
);

    `RRCG_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `RRCG_ASSERT_NEXT(a_rows_contiguous, result_strobe && !last_row, result_strobe)
    `RRCG_ASSERT_NEXT(a_core_step, result_strobe && !last_row, core_coord == $past(core_coord) + 6'd1)
    `RRCG_ASSERT_NEXT(a_gap_after_last, result_strobe && last_row, !result_strobe)
    `RRCG_ASSERT_SAME(a_first_core_zero, result_strobe && !$past(result_strobe), core_coord == 6'd0)

endmodule

bind round_robin_rank_coordinate_generator_top rrcg_checker u_rrcg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .core_coord    (core_coord),
    .last_row      (last_row)
);
